// ----- sv/rvis_pkg.sv -----
// Shared types, codes and defaults for the register machine instruction step block.
package rvis_pkg;

    localparam int NUM_REGS_DEFAULT      = 8;
    localparam int PROGRAM_DEPTH_DEFAULT = 1024;

    localparam int CMD_W    = 3;
    localparam int REG_IDX_W = 3;
    localparam int WORD_W   = 32;
    localparam int COND_W   = 3;
    localparam int OFFSET_W = 11;
    localparam int LEN_W    = 11;
    localparam int OUT_PTR_W = 10;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_INC     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEC     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PRINT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMPARE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_JUMP    = 3'd5;

    localparam logic [COND_W-1:0] COND_ALWAYS        = 3'd0;
    localparam logic [COND_W-1:0] COND_LESS          = 3'd1;
    localparam logic [COND_W-1:0] COND_LESS_EQUAL    = 3'd2;
    localparam logic [COND_W-1:0] COND_GREATER       = 3'd3;
    localparam logic [COND_W-1:0] COND_GREATER_EQUAL = 3'd4;
    localparam logic [COND_W-1:0] COND_EQUAL         = 3'd5;
    localparam logic [COND_W-1:0] COND_NOT_EQUAL     = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_RUNNING  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FINISHED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAULT    = 2'd2;

    typedef struct packed {
        logic [OUT_PTR_W-1:0]     next_pointer;
        logic                     print_valid;
        logic signed [WORD_W-1:0] print_value;
        logic [STATUS_W-1:0]      run_status;
    } result_t;

    typedef struct packed {
        logic rf_we;
        logic cmp_we;
        logic ptr_we;
        logic halt_set;
    } exec_ctl_t;

endpackage

// ----- sv/rvis_regfile.sv -----
// Register file memory with reset valid bits, registered dual reads and write bypass.
module rvis_regfile #(
    parameter int NUM_REGS = rvis_pkg::NUM_REGS_DEFAULT,
    parameter int IDX_W    = $clog2(NUM_REGS)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             rd_en,
    input  logic [IDX_W-1:0]                 raddr_a,
    input  logic [IDX_W-1:0]                 raddr_b,
    input  logic                             we,
    input  logic [IDX_W-1:0]                 waddr,
    input  logic [rvis_pkg::WORD_W-1:0]      wdata,
    output logic [rvis_pkg::WORD_W-1:0]      rdata_a,
    output logic [rvis_pkg::WORD_W-1:0]      rdata_b
);

    logic [rvis_pkg::WORD_W-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]         valid_reg;
    logic [rvis_pkg::WORD_W-1:0] rdata_a_reg;
    logic [rvis_pkg::WORD_W-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (we && (waddr == raddr_a)) begin
                rdata_a_reg <= wdata;
            end else if (valid_reg[raddr_a]) begin
                rdata_a_reg <= mem[raddr_a];
            end else begin
                rdata_a_reg <= '0;
            end
            if (we && (waddr == raddr_b)) begin
                rdata_b_reg <= wdata;
            end else if (valid_reg[raddr_b]) begin
                rdata_b_reg <= mem[raddr_b];
            end else begin
                rdata_b_reg <= '0;
            end
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- sv/rvis_exec.sv -----
// Execute logic: decodes one instruction and computes the state updates and its result.
module rvis_exec #(
    parameter int PTR_W = 12
) (
    input  logic [rvis_pkg::CMD_W-1:0]           command,
    input  logic signed [rvis_pkg::WORD_W-1:0]   immediate_value,
    input  logic [rvis_pkg::COND_W-1:0]          jump_condition,
    input  logic signed [rvis_pkg::OFFSET_W-1:0] jump_offset,
    input  logic [rvis_pkg::WORD_W-1:0]          rdata_a,
    input  logic [rvis_pkg::WORD_W-1:0]          rdata_b,
    input  logic [rvis_pkg::WORD_W-1:0]          cmp_diff,
    input  logic signed [PTR_W-1:0]              ip,
    input  logic                                 halted,
    input  logic signed [PTR_W-1:0]              eff_len,
    output rvis_pkg::exec_ctl_t                  ctl,
    output logic [rvis_pkg::WORD_W-1:0]          rf_wdata,
    output logic [rvis_pkg::WORD_W-1:0]          cmp_value,
    output logic signed [PTR_W-1:0]              ip_next,
    output rvis_pkg::result_t                    result
);

    logic                   neg;
    logic                   zero;
    logic                   taken;
    logic                   pre_oor;
    logic                   post_oor;
    logic signed [PTR_W-1:0] ip_step;
    logic signed [PTR_W-1:0] off_ext;

    assign neg     = cmp_diff[rvis_pkg::WORD_W-1];
    assign zero    = (cmp_diff == '0);
    assign off_ext = PTR_W'(jump_offset);
    assign pre_oor = (ip < 0) || (ip >= eff_len);

    always_comb begin
        case (jump_condition)
            rvis_pkg::COND_ALWAYS:        taken = 1'b1;
            rvis_pkg::COND_LESS:          taken = neg;
            rvis_pkg::COND_LESS_EQUAL:    taken = neg || zero;
            rvis_pkg::COND_GREATER:       taken = !neg && !zero;
            rvis_pkg::COND_GREATER_EQUAL: taken = !neg;
            rvis_pkg::COND_EQUAL:         taken = zero;
            rvis_pkg::COND_NOT_EQUAL:     taken = !zero;
            default:                      taken = 1'b0;
        endcase
    end

    always_comb begin
        ctl        = '0;
        rf_wdata   = rdata_a;
        cmp_value  = rdata_a - rdata_b;
        ip_step    = ip + PTR_W'(1);
        result     = '0;
        unique case (command)
            rvis_pkg::CMD_INC: begin
                ctl.rf_we = 1'b1;
                rf_wdata  = rdata_a + rvis_pkg::WORD_W'(1);
            end
            rvis_pkg::CMD_DEC: begin
                ctl.rf_we = 1'b1;
                rf_wdata  = rdata_a - rvis_pkg::WORD_W'(1);
            end
            rvis_pkg::CMD_LOAD: begin
                ctl.rf_we = 1'b1;
                rf_wdata  = immediate_value;
            end
            rvis_pkg::CMD_PRINT: begin
                result.print_valid = 1'b1;
                result.print_value = rdata_a;
            end
            rvis_pkg::CMD_COMPARE: begin
                ctl.cmp_we = 1'b1;
            end
            rvis_pkg::CMD_JUMP: begin
                if (taken && (jump_offset != '0)) begin
                    ip_step = ip + off_ext;
                end
            end
            default: begin
            end
        endcase
        ip_next = ip_step;
        ctl.ptr_we = 1'b1;
        post_oor = (ip_step < 0) || (ip_step >= eff_len);
        if (halted || pre_oor) begin
            ctl      = '0;
            ctl.halt_set = 1'b1;
            ip_next  = ip;
            result   = '0;
            result.run_status = (ip < 0) ? rvis_pkg::STATUS_FAULT : rvis_pkg::STATUS_FINISHED;
        end else if (post_oor) begin
            ctl.halt_set = 1'b1;
            result.next_pointer = '0;
            result.run_status = (ip_step < 0) ? rvis_pkg::STATUS_FAULT
                                              : rvis_pkg::STATUS_FINISHED;
        end else begin
            result.next_pointer = ip_step[rvis_pkg::OUT_PTR_W-1:0];
            result.run_status   = rvis_pkg::STATUS_RUNNING;
        end
    end

endmodule

// ----- sv/register_vm_instruction_step.sv -----
// Top level of the register machine instruction step block.
// An accepted item is held in the input register, its result in the result register.
// Throughput: one item per cycle unless m_ready stalls the result register, set by
// the single execute stage between them, with register file reads bypassed.
// Reset: synchronous active-low aresetn clears the registers (via valid bits),
// comparison difference, pointer, halt flag and program length; no clearing pass.
module register_vm_instruction_step #(
    parameter int NUM_REGS      = rvis_pkg::NUM_REGS_DEFAULT,
    parameter int PROGRAM_DEPTH = rvis_pkg::PROGRAM_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rvis_pkg::LEN_W-1:0]           cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rvis_pkg::CMD_W-1:0]           s_command,
    input  logic [rvis_pkg::REG_IDX_W-1:0]       s_first_register,
    input  logic [rvis_pkg::REG_IDX_W-1:0]       s_second_register,
    input  logic signed [rvis_pkg::WORD_W-1:0]   s_immediate_value,
    input  logic [rvis_pkg::COND_W-1:0]          s_jump_condition,
    input  logic signed [rvis_pkg::OFFSET_W-1:0] s_jump_offset,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rvis_pkg::OUT_PTR_W-1:0]       m_next_pointer,
    output logic                                 m_print_valid,
    output logic signed [rvis_pkg::WORD_W-1:0]   m_print_value,
    output logic [rvis_pkg::STATUS_W-1:0]        m_run_status
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int PTR_W = $clog2(PROGRAM_DEPTH + 1024) + 1;

    logic [rvis_pkg::LEN_W-1:0]           program_length_reg;
    logic [rvis_pkg::WORD_W-1:0]          cmp_diff_reg;
    logic signed [PTR_W-1:0]              ip_reg;
    logic                                 halted_reg;

    logic                                 ex_valid_reg;
    logic                                 ex_valid_next;
    logic [rvis_pkg::CMD_W-1:0]           ex_command_reg;
    logic [IDX_W-1:0]                     ex_idx_a_reg;
    logic signed [rvis_pkg::WORD_W-1:0]   ex_imm_reg;
    logic [rvis_pkg::COND_W-1:0]          ex_cond_reg;
    logic signed [rvis_pkg::OFFSET_W-1:0] ex_offset_reg;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    rvis_pkg::result_t                    out_result_reg;

    logic                                 accept;
    logic                                 ex_advance;
    logic [IDX_W-1:0]                     idx_wrap [2**rvis_pkg::REG_IDX_W];
    logic [IDX_W-1:0]                     idx_a;
    logic [IDX_W-1:0]                     idx_b;
    logic [rvis_pkg::WORD_W-1:0]          rdata_a;
    logic [rvis_pkg::WORD_W-1:0]          rdata_b;
    logic signed [PTR_W-1:0]              eff_len;
    logic signed [PTR_W-1:0]              len_ext;
    rvis_pkg::exec_ctl_t                  ctl;
    logic [rvis_pkg::WORD_W-1:0]          rf_wdata;
    logic [rvis_pkg::WORD_W-1:0]          cmp_value;
    logic signed [PTR_W-1:0]              ip_next;
    rvis_pkg::result_t                    result;

    assign cfg_ready  = 1'b1;
    assign ex_advance = ex_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !ex_valid_reg || ex_advance;
    assign accept     = s_valid && s_ready;

    for (genvar i = 0; i < 2**rvis_pkg::REG_IDX_W; i++) begin : g_idx_wrap
        assign idx_wrap[i] = IDX_W'(i % NUM_REGS);
    end

    assign idx_a = idx_wrap[s_first_register];
    assign idx_b = idx_wrap[s_second_register];

    assign len_ext = $signed({{(PTR_W - rvis_pkg::LEN_W){1'b0}}, program_length_reg});
    assign eff_len = (len_ext > PTR_W'(PROGRAM_DEPTH)) ? PTR_W'(PROGRAM_DEPTH) : len_ext;

    rvis_regfile #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .raddr_a (idx_a),
        .raddr_b (idx_b),
        .we      (ex_advance && ctl.rf_we),
        .waddr   (ex_idx_a_reg),
        .wdata   (rf_wdata),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    rvis_exec #(
        .PTR_W (PTR_W)
    ) u_exec (
        .command         (ex_command_reg),
        .immediate_value (ex_imm_reg),
        .jump_condition  (ex_cond_reg),
        .jump_offset     (ex_offset_reg),
        .rdata_a         (rdata_a),
        .rdata_b         (rdata_b),
        .cmp_diff        (cmp_diff_reg),
        .ip              (ip_reg),
        .halted          (halted_reg),
        .eff_len         (eff_len),
        .ctl             (ctl),
        .rf_wdata        (rf_wdata),
        .cmp_value       (cmp_value),
        .ip_next         (ip_next),
        .result          (result)
    );

    always_comb begin
        ex_valid_next = ex_valid_reg;
        if (accept) begin
            ex_valid_next = 1'b1;
        end else if (ex_advance) begin
            ex_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (ex_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            program_length_reg <= '0;
            cmp_diff_reg       <= '0;
            ip_reg             <= '0;
            halted_reg         <= 1'b0;
            ex_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                program_length_reg <= cfg_data;
            end
            if (ex_advance) begin
                if (ctl.cmp_we) begin
                    cmp_diff_reg <= cmp_value;
                end
                if (ctl.ptr_we) begin
                    ip_reg <= ip_next;
                end
                if (ctl.halt_set) begin
                    halted_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_command_reg <= s_command;
            ex_idx_a_reg   <= idx_a;
            ex_imm_reg     <= s_immediate_value;
            ex_cond_reg    <= s_jump_condition;
            ex_offset_reg  <= s_jump_offset;
        end
        if (ex_advance) begin
            out_result_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_next_pointer = out_result_reg.next_pointer;
    assign m_print_valid  = out_result_reg.print_valid;
    assign m_print_value  = out_result_reg.print_value;
    assign m_run_status   = out_result_reg.run_status;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("Halt flag cleared without reset.");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (ex_valid_reg && out_valid_reg && !m_ready))
        else $error("Input stalled while the pipeline could move.");

    a_halted_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_run_status != rvis_pkg::STATUS_RUNNING))
            |-> (m_next_pointer == '0))
        else $error("Halted result carries a pointer.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_run_status == rvis_pkg::STATUS_RUNNING)
            || (m_run_status == rvis_pkg::STATUS_FINISHED)
            || (m_run_status == rvis_pkg::STATUS_FAULT)))
        else $error("Result status is not a defined code.");
`endif

endmodule
